[src/sha_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and functions of the SHA-256 stream hasher.
// ---------------------------------------------------------------------------
package sha_pkg;

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] StartHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic OpAbsorb = 1'b0;
    localparam logic OpFinish = 1'b1;

    typedef logic [31:0] sha_vars_t [8];

    typedef struct packed {
        logic       byte_en;
        logic [7:0] byte_val;
        logic       word_en;
    } sha_blk_ctl_t;

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        small_sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        small_sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage

[src/sha_sched.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha_sched
// Block store and message schedule: bytes shift in, words shift through.
// ---------------------------------------------------------------------------
module sha_sched (
    input  logic                  clk,
    input  sha_pkg::sha_blk_ctl_t ctl,
    output logic [31:0]           w_cur
);
    import sha_pkg::*;

    logic [511:0] blk_reg;
    logic [31:0]  w_new;

    function automatic logic [31:0] wsel(input logic [511:0] b, input int unsigned i);
        wsel = b[511 - 32 * i -: 32];
    endfunction

    assign w_cur = wsel(blk_reg, 0);
    assign w_new = wsel(blk_reg, 0) + small_sig0(wsel(blk_reg, 1)) + wsel(blk_reg, 9)
                 + small_sig1(wsel(blk_reg, 14));

    always_ff @(posedge clk)
    begin
        if (ctl.byte_en)
        begin
            blk_reg <= {blk_reg[503:0], ctl.byte_val};
        end
        else if (ctl.word_en)
        begin
            blk_reg <= {blk_reg[479:0], w_new};
        end
    end

endmodule

[src/sha_round.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha_round
// One SHA-256 compression round, shared over all 64 rounds.
// ---------------------------------------------------------------------------
module sha_round (
    input  sha_pkg::sha_vars_t v_in,
    input  logic [31:0]        k,
    input  logic [31:0]        w,
    output sha_pkg::sha_vars_t v_out
);
    import sha_pkg::*;

    logic [31:0] t1;
    logic [31:0] t2;

    assign t1 = v_in[7] + big_sig1(v_in[4]) + ((v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]))
              + k + w;
    assign t2 = big_sig0(v_in[0])
              + ((v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]));

    always_comb
    begin
        v_out[7] = v_in[6];
        v_out[6] = v_in[5];
        v_out[5] = v_in[4];
        v_out[4] = v_in[3] + t1;
        v_out[3] = v_in[2];
        v_out[2] = v_in[1];
        v_out[1] = v_in[0];
        v_out[0] = t1 + t2;
    end

endmodule

[src/sha256_stream_hash.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha256_stream_hash
// SHA-256 over a byte stream with a single shared round unit.
// ---------------------------------------------------------------------------
// An absorb request shifts in one byte; a block's 64th byte then runs the
// rounds and folds the result into the hash, all through the one round unit.
// A finish request shifts in 64 - fill padding bytes one a cycle, then
// compresses; fill >= 56 adds a second block of 64 padding bytes. The eight
// digest words then leave one per output request. s_tready is low from a
// block's last byte until done, and from a finish request to the last word.
module sha256_stream_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero
    output logic        m_tlast    // last_word
);
    import sha_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PAD  = 5'b00010,
        ST_COMP = 5'b00100,
        ST_ADD  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t       state_reg, state_next;
    state_t       after_reg, after_next;
    logic [60:0]  total_reg, total_next;
    logic [63:0]  len_reg, len_next;
    logic [5:0]   pos_reg, pos_next;
    logic         first_reg, first_next;
    logic         len_ok_reg, len_ok_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic [2:0]   idx_reg, idx_next;
    sha_vars_t    hash_reg, hash_next;
    sha_vars_t    v_reg, v_next, v_round;
    sha_blk_ctl_t blk_ctl;
    logic [31:0]  w_cur;
    logic [7:0]   pad_val;
    logic [5:0]   fill;

    sha_sched u_sched (
        .clk   (clk),
        .ctl   (blk_ctl),
        .w_cur (w_cur)
    );

    sha_round u_round (
        .v_in  (v_reg),
        .k     (RoundK[rnd_reg]),
        .w     (w_cur),
        .v_out (v_round)
    );

    assign fill     = total_reg[5:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {5'b0, idx_reg, hash_reg[idx_reg]};
    assign m_tlast  = (idx_reg == 3'd7);

    always_comb
    begin
        if (first_reg)
        begin
            pad_val = PadByte;
        end
        else if (len_ok_reg && pos_reg[5:3] == 3'b111)
        begin
            pad_val = 8'(len_reg >> {~pos_reg[2:0], 3'b000});
        end
        else
        begin
            pad_val = 8'h00;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        after_next      = after_reg;
        total_next      = total_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        first_next      = first_reg;
        len_ok_next     = len_ok_reg;
        rnd_next        = rnd_reg;
        idx_next        = idx_reg;
        hash_next       = hash_reg;
        v_next          = v_reg;
        blk_ctl.byte_en  = 1'b0;
        blk_ctl.byte_val = s_tdata;
        blk_ctl.word_en  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == OpAbsorb)
                    begin
                        blk_ctl.byte_en = 1'b1;
                        total_next = total_reg + 61'd1;
                        if (fill == 6'd63)
                        begin
                            state_next = ST_COMP;
                            after_next = ST_IDLE;
                            v_next     = hash_reg;
                            rnd_next   = 6'd0;
                        end
                    end
                    else
                    begin
                        len_next    = {total_reg, 3'b000};
                        pos_next    = fill;
                        first_next  = 1'b1;
                        len_ok_next = (fill[5:3] != 3'b111);
                        state_next  = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                blk_ctl.byte_en  = 1'b1;
                blk_ctl.byte_val = pad_val;
                first_next = 1'b0;
                pos_next   = pos_reg + 6'd1;
                if (pos_reg == 6'd63)
                begin
                    state_next  = ST_COMP;
                    after_next  = len_ok_reg ? ST_OUT : ST_PAD;
                    len_ok_next = 1'b1;
                    v_next      = hash_reg;
                    rnd_next    = 6'd0;
                end
            end
            ST_COMP:
            begin
                blk_ctl.word_en = 1'b1;
                v_next   = v_round;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + v_reg[i];
                end
                idx_next   = 3'd0;
                state_next = after_reg;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        hash_next  = StartHash;
                        total_next = 61'd0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            after_reg  <= ST_IDLE;
            total_reg  <= 61'd0;
            first_reg  <= 1'b0;
            len_ok_reg <= 1'b0;
            pos_reg    <= 6'd0;
            rnd_reg    <= 6'd0;
            idx_reg    <= 3'd0;
            hash_reg   <= StartHash;
        end
        else
        begin
            state_reg  <= state_next;
            after_reg  <= after_next;
            total_reg  <= total_next;
            first_reg  <= first_next;
            len_ok_reg <= len_ok_next;
            pos_reg    <= pos_next;
            rnd_reg    <= rnd_next;
            idx_reg    <= idx_next;
            hash_reg   <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        v_reg   <= v_next;
    end

endmodule

[src/sha_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha_checker
// Port-level checks of the SHA-256 stream hasher, bound to the top level.
// ---------------------------------------------------------------------------
module sha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);
    import sha_pkg::*;

    // result stalled holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled digest word changed");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while digest pending");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7)))
        else $error("tlast and word index disagree");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("digest did not end after last word");

    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == OpFinish |=> !s_tready && !m_tvalid)
        else $error("finish request not processed");

endmodule

bind sha256_stream_hash sha_checker u_sha_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[dv/sha256_digest_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha256_digest_checker
// Watches both streams of the hasher, computes SHA-256 of every message seen
// on the request side, and compares each digest word that leaves the block.
// ---------------------------------------------------------------------------
module sha256_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_words
);
    import sha_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    logic [31:0]  hash_state [8];
    logic [7:0]   msg_block [64];
    logic [60:0]  msg_bytes;
    digest_word_t digest_queue [$];

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            x = w[i-15];
            y = w[i-2];
            w[i] = w[i-16] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w[i-7]
                 + (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
        end
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endtask

    task automatic absorb_request(input logic op, input logic [7:0] data);
        int unsigned fill;
        logic [63:0] bits;
        digest_word_t dw;
        fill = msg_bytes[5:0];
        if (op == OpAbsorb)
        begin
            msg_block[fill] = data;
            msg_bytes = msg_bytes + 61'd1;
            if (fill == 63)
                compress();
            return;
        end
        bits = {msg_bytes, 3'b000};
        msg_block[fill] = PadByte;
        for (int i = fill + 1; i < 64; i++)
            msg_block[i] = 8'h00;
        if (fill >= 56)
        begin
            compress();
            for (int i = 0; i < 64; i++)
                msg_block[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++)
            msg_block[56+i] = bits[63-8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++)
        begin
            dw.word = hash_state[i];
            dw.index = i[2:0];
            dw.last = (i == 7);
            digest_queue.push_back(dw);
        end
        hash_state = StartHash;
        msg_bytes = '0;
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending_words = 0;
        hash_state = StartHash;
        msg_bytes = '0;
    end

    always @(posedge clk)
    begin
        digest_word_t want;
        if (rst_n && s_tvalid && s_tready)
            absorb_request(s_tuser, s_tdata);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digest_queue.size() == 0)
                report("unexpected digest word", {24'd0, m_tdata}, 64'd0);
            else
            begin
                want = digest_queue.pop_front();
                if (m_tdata[31:0] !== want.word)
                    report("digest_word", {32'd0, m_tdata[31:0]}, {32'd0, want.word});
                if (m_tdata[34:32] !== want.index)
                    report("word_index", {61'd0, m_tdata[34:32]}, {61'd0, want.index});
                if (m_tdata[39:35] !== 5'b0)
                    report("tdata padding", {59'd0, m_tdata[39:35]}, 64'd0);
                if (m_tlast !== want.last)
                    report("last_word", {63'd0, m_tlast}, {63'd0, want.last});
            end
        end
        pending_words = digest_queue.size();
    end

endmodule

[dv/sha256_stream_hash_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha256_stream_hash_tb
// Drives byte and finish requests into the hasher with random gaps and
// output stalls, including one long output hold-off; the checker module
// computes the expected digests and counts mismatches.
// ---------------------------------------------------------------------------
module sha256_stream_hash_tb;
    import sha_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending_words;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;

    sha256_stream_hash u_top (.*);

    sha256_digest_checker u_chk (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // starts and ends at a falling edge; valid stays up between back-to-back requests
    task automatic send(input logic op, input logic [7:0] data);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_message(input int len, input int mode);
        for (int i = 0; i < len; i++)
            send(OpAbsorb, mode == 0 ? 8'h00 : mode == 1 ? 8'hff : 8'($urandom));
        send(OpFinish, 8'($urandom));
    endtask

    always @(negedge clk)
        m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

    initial
    begin
        int count;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OpAbsorb;
        m_tready = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 85;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_message(0, 2);
        send(OpFinish, 8'hff);
        send_message(3, 0);
        send_message(3, 1);
        send_message(1, 2);

        count = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = phase == 0 ? 24 : phase == 1 ? 85 : 0;
            recv_idle_pct = phase == 0 ? 85 : phase == 1 ? 24 : 0;
            if (phase == 1)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            while (count < 100 * (phase + 1))
            begin
                int len;
                case ($urandom_range(5))
                    0: len = $urandom_range(55, 64);
                    1: len = $urandom_range(120, 130);
                    2: len = 0;
                    default: len = $urandom_range(1, 20);
                endcase
                send_message(len, $urandom_range(9) == 0 ? $urandom_range(1) : 2);
                count += len + 1;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_words != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending_words == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[sha256_stream_hash.f]
src/sha_pkg.sv
src/sha_sched.sv
src/sha_round.sv
src/sha256_stream_hash.sv
src/sha_checker.sv
dv/sha256_digest_checker.sv
dv/sha256_stream_hash_tb.sv
